// ===== rtl/grid_open_list_heap_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the grid open list heap core.
// Each macro compiles to a concurrent assertion on i_clk with the active-low
// reset as disable condition, or to nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef GRID_OPEN_LIST_HEAP_CORE_MACROS_SVH
`define GRID_OPEN_LIST_HEAP_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Condition a implies condition b in the same cycle.
`define GOLHC_ASSERT_IMPL(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Condition a implies condition b in the following cycle.
`define GOLHC_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("assertion failed");
// Condition c never holds.
`define GOLHC_ASSERT_NEVER(lbl, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(c)) \
        else $error("assertion failed");
`else
`define GOLHC_ASSERT_IMPL(lbl, a, b)
`define GOLHC_ASSERT_NEXT(lbl, a, b)
`define GOLHC_ASSERT_NEVER(lbl, c)
`endif

`endif

// ===== rtl/golh_pkg.sv =====
// ----------------------------------------------------------------------------
// golh_pkg
// Shared types and constants of the grid open list heap core.
// ----------------------------------------------------------------------------
package golh_pkg;

    // Default grid limits.
    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 64;

    // Field widths.
    localparam int CW   = 6;   // coordinate
    localparam int DW   = 7;   // grid dimension register
    localparam int COSTW = 24; // cost, 16.8 fixed point
    localparam int KEYW = 25;  // total cost
    localparam int EXPW = 32;

    localparam logic [DW-1:0]    DIM_RESET = 7'd64;
    localparam logic [COSTW-1:0] INF_COST  = 24'hFFFFFF;

    // Operation codes.
    localparam logic [1:0] KIND_ENQ = 2'd0;
    localparam logic [1:0] KIND_DEQ = 2'd1;
    localparam logic [1:0] KIND_LKP = 2'd2;
    localparam logic [1:0] KIND_CLR = 2'd3;

    // Cell status codes.
    localparam logic [1:0] ST_UNVISITED = 2'd0;
    localparam logic [1:0] ST_QUEUED    = 2'd1;
    localparam logic [1:0] ST_CLOSED    = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // One cell record as held in the cell store.
    typedef struct packed {
        logic [1:0]       status;
        logic [CW-1:0]    self_x;
        logic [CW-1:0]    self_y;
        logic [CW-1:0]    pred_x;
        logic [CW-1:0]    pred_y;
        logic [COSTW-1:0] come;
        logic [COSTW-1:0] go;
    } t_cell_rec;

    // Write request into the cell store.
    typedef struct packed {
        logic      en;
        t_cell_rec data;
    } t_cell_wr;

    localparam t_cell_rec NONE_REC = '{status: ST_NONE, self_x: '0, self_y: '0,
                                       pred_x: '0, pred_y: '0, come: INF_COST,
                                       go: '0};

endpackage

// ===== rtl/golh_cell_mem.sv =====
// ----------------------------------------------------------------------------
// golh_cell_mem
// Cell record store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module golh_cell_mem #(
    parameter int CELLS = 4096,
    parameter int AW    = 12
) (
    input  logic               i_clk,
    input  golh_pkg::t_cell_wr i_wr,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [AW-1:0]      i_rd_addr,
    output golh_pkg::t_cell_rec o_rd_data
);
    import golh_pkg::*;

    t_cell_rec r_mem [CELLS];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== rtl/golh_heap_mem.sv =====
// ----------------------------------------------------------------------------
// golh_heap_mem
// Heap slot store (two registered reads, one write) and the cell to slot
// place store (one registered read, one write).
// ----------------------------------------------------------------------------
module golh_heap_mem #(
    parameter int CELLS = 4096,
    parameter int AW    = 12,
    parameter int EW    = 37
) (
    input  logic          i_clk,
    input  logic          i_slot_we,
    input  logic [AW-1:0] i_slot_waddr,
    input  logic [EW-1:0] i_slot_wdata,
    input  logic [AW-1:0] i_slot_ra_addr,
    input  logic [AW-1:0] i_slot_rb_addr,
    output logic [EW-1:0] o_slot_ra,
    output logic [EW-1:0] o_slot_rb,
    input  logic          i_place_we,
    input  logic [AW-1:0] i_place_waddr,
    input  logic [AW-1:0] i_place_wdata,
    input  logic [AW-1:0] i_place_raddr,
    output logic [AW-1:0] o_place_rd
);
    import golh_pkg::*;

    logic [EW-1:0] r_slot  [CELLS];
    logic [AW-1:0] r_place [CELLS];

    // Slot store.
    always_ff @(posedge i_clk) begin
        if (i_slot_we) begin
            r_slot[i_slot_waddr] <= i_slot_wdata;
        end
        o_slot_ra <= r_slot[i_slot_ra_addr];
        o_slot_rb <= r_slot[i_slot_rb_addr];
    end

    // Place store.
    always_ff @(posedge i_clk) begin
        if (i_place_we) begin
            r_place[i_place_waddr] <= i_place_wdata;
        end
        o_place_rd <= r_place[i_place_raddr];
    end

endmodule

// ===== rtl/grid_open_list_heap_core.sv =====
// ----------------------------------------------------------------------------
// grid_open_list_heap_core
// Node store and binary-heap open list of a grid path search.
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low. i_kind selects
// enqueue, dequeue, lookup or clear. Exactly one result follows, shown for
// one cycle with o_valid high; the receiver cannot stall it, and the next
// request may be taken in the cycle the result is shown.
// A rejected enqueue or lookup, or a dequeue of an empty list, is answered from
// the idle state. An enqueue writes its record and sifts the entry up, then down
// the heap; a dequeue moves the last entry to the root and sifts it down. Each
// heap level walked is one read of the slot store and one compare and write-back.
// Clear and reset sweep all MAX_COLS*MAX_ROWS entries of the cell store one entry
// a cycle, with o_busy high; a clear then returns the invalid record in the cycle
// after the sweep ends.
// Grid dimensions are written through the i_cfg_* channel, always ready,
// and take effect at the next clear.
// After reset both dimensions are 64 and the store is swept once.
// ----------------------------------------------------------------------------
`include "grid_open_list_heap_core_macros.svh"

module grid_open_list_heap_core #(
    parameter int MAX_COLS = golh_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = golh_pkg::MAX_ROWS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [1:0]                i_kind,
    input  logic [golh_pkg::CW-1:0]   i_pos_x,
    input  logic [golh_pkg::CW-1:0]   i_pos_y,
    input  logic [golh_pkg::CW-1:0]   i_pred_in_x,
    input  logic [golh_pkg::CW-1:0]   i_pred_in_y,
    input  logic [golh_pkg::COSTW-1:0] i_in_cost_to_come,
    input  logic [golh_pkg::COSTW-1:0] i_in_cost_to_go,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [golh_pkg::DW-1:0]   i_cfg_data,
    output logic                      o_valid,
    output logic [1:0]                o_node_status,
    output logic [golh_pkg::CW-1:0]   o_node_x,
    output logic [golh_pkg::CW-1:0]   o_node_y,
    output logic [golh_pkg::CW-1:0]   o_node_pred_x,
    output logic [golh_pkg::CW-1:0]   o_node_pred_y,
    output logic [golh_pkg::COSTW-1:0] o_node_cost_to_come,
    output logic [golh_pkg::COSTW-1:0] o_node_cost_to_go,
    output logic                      o_queue_empty,
    output logic [golh_pkg::EXPW-1:0] o_expansions
);
    import golh_pkg::*;

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int EW    = KEYW + AW;

    typedef enum logic [12:0] {
        S_CLR     = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_ENQ_WR  = 13'b0000000000100,
        S_DEQ_TOP = 13'b0000000001000,
        S_SU_RD   = 13'b0000000010000,
        S_SU_CMP  = 13'b0000000100000,
        S_SD_RD   = 13'b0000001000000,
        S_SD_CMP  = 13'b0000010000000,
        S_FIN_RD  = 13'b0000100000000,
        S_FIN     = 13'b0001000000000,
        S_LKP     = 13'b0010000000000,
        S_SPARE_A = 13'b0100000000000,
        S_SPARE_B = 13'b1000000000000
    } t_state;

    function automatic logic [DW-1:0] sat_dim(input logic [DW-1:0] g, input int lim);
        logic [DW-1:0] res;
        res = g;
        if (32'(g) > lim) begin
            res = DW'(lim);
        end
        return res;
    endfunction

    t_state          r_state, n_state;
    logic [DW-1:0]   r_grid_w, r_grid_h;
    logic [DW-1:0]   r_act_w, n_act_w, r_act_h, n_act_h;
    logic [AW:0]     r_size, n_size;
    logic [EXPW-1:0] r_exp, n_exp;
    logic [AW-1:0]   r_sw_i, n_sw_i;
    logic [DW-1:0]   r_cx, n_cx, r_cy, n_cy;
    logic            r_clr_reply, n_clr_reply;
    logic [1:0]      r_kind, n_kind;
    logic [AW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_px, n_px, r_py, n_py;
    logic [CW-1:0]   r_prx, n_prx, r_pry, n_pry;
    logic [COSTW-1:0] r_come, n_come, r_go, n_go;
    t_cell_rec       r_rec, n_rec;
    logic [AW-1:0]   r_top, n_top;
    logic [EW-1:0]   r_item, n_item;
    logic [AW-1:0]   r_pos, n_pos;
    logic            r_valid, n_valid;
    t_cell_rec       r_out, n_out;
    logic            r_out_empty, n_out_empty;
    logic [EXPW-1:0] r_out_exp, n_out_exp;

    t_cell_wr        cell_wr;
    logic [AW-1:0]   cell_waddr, cell_raddr;
    t_cell_rec       cell_rd;
    logic            slot_we, place_we;
    logic [AW-1:0]   slot_waddr, slot_ra_addr, slot_rb_addr;
    logic [EW-1:0]   slot_wdata, slot_ra, slot_rb;
    logic [AW-1:0]   place_waddr, place_wdata, place_raddr, place_rd;

    logic            done;
    t_cell_rec       res_rec;
    logic            in_ok;
    logic [13:0]     in_lin;
    logic [AW-1:0]   in_idx;
    logic            sw_in_grid;
    t_cell_rec       sw_rec;
    logic [AW:0]     lft, rgt;
    logic [EW-1:0]   best;
    logic [AW-1:0]   best_pos;
    logic [AW-1:0]   par;
    logic            heap_done;

    golh_cell_mem #(.CELLS(CELLS), .AW(AW)) u_cell (
        .i_clk     (i_clk),
        .i_wr      (cell_wr),
        .i_wr_addr (cell_waddr),
        .i_rd_addr (cell_raddr),
        .o_rd_data (cell_rd)
    );

    golh_heap_mem #(.CELLS(CELLS), .AW(AW), .EW(EW)) u_heap (
        .i_clk          (i_clk),
        .i_slot_we      (slot_we),
        .i_slot_waddr   (slot_waddr),
        .i_slot_wdata   (slot_wdata),
        .i_slot_ra_addr (slot_ra_addr),
        .i_slot_rb_addr (slot_rb_addr),
        .o_slot_ra      (slot_ra),
        .o_slot_rb      (slot_rb),
        .i_place_we     (place_we),
        .i_place_waddr  (place_waddr),
        .i_place_wdata  (place_wdata),
        .i_place_raddr  (place_raddr),
        .o_place_rd     (place_rd)
    );

    // Position check and linear index of the incoming request.
    always_comb begin
        in_ok  = (DW'(i_pos_x) < r_act_w) && (DW'(i_pos_y) < r_act_h);
        in_lin = 14'(i_pos_y) * 14'(r_act_w) + 14'(i_pos_x);
        in_idx = AW'(in_lin);
    end

    // Record written by the clearing sweep.
    always_comb begin
        sw_in_grid    = (r_cy < r_act_h) && (r_act_w != '0);
        sw_rec        = '0;
        sw_rec.status = ST_UNVISITED;
        sw_rec.come   = INF_COST;
        if (sw_in_grid) begin
            sw_rec.self_x = r_cx[CW-1:0];
            sw_rec.self_y = r_cy[CW-1:0];
            sw_rec.pred_x = r_cx[CW-1:0];
            sw_rec.pred_y = r_cy[CW-1:0];
        end
    end

    // Heap walk helpers.
    always_comb begin
        lft      = {r_pos, 1'b1};
        rgt      = lft + (AW+1)'(1);
        par      = (r_pos - AW'(1)) >> 1;
        best     = slot_ra;
        best_pos = AW'(lft);
        if ((rgt < r_size) && (slot_rb < slot_ra)) begin
            best     = slot_rb;
            best_pos = AW'(rgt);
        end
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_act_w     = r_act_w;
        n_act_h     = r_act_h;
        n_size      = r_size;
        n_exp       = r_exp;
        n_sw_i      = r_sw_i;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_clr_reply = r_clr_reply;
        n_kind      = r_kind;
        n_idx       = r_idx;
        n_px        = r_px;
        n_py        = r_py;
        n_prx       = r_prx;
        n_pry       = r_pry;
        n_come      = r_come;
        n_go        = r_go;
        n_rec       = r_rec;
        n_top       = r_top;
        n_item      = r_item;
        n_pos       = r_pos;
        n_valid     = 1'b0;
        n_out       = r_out;
        n_out_empty = r_out_empty;
        n_out_exp   = r_out_exp;

        cell_wr.en   = 1'b0;
        cell_wr.data = r_rec;
        cell_waddr   = r_idx;
        cell_raddr   = r_idx;
        slot_we      = 1'b0;
        slot_waddr   = r_pos;
        slot_wdata   = r_item;
        slot_ra_addr = '0;
        slot_rb_addr = '0;
        place_we     = 1'b0;
        place_waddr  = r_item[AW-1:0];
        place_wdata  = r_pos;
        place_raddr  = r_idx;
        done         = 1'b0;
        res_rec      = NONE_REC;
        heap_done    = 1'b0;

        case (r_state)
            // Clearing sweep, one cell a cycle.
            S_CLR: begin
                cell_wr.en   = 1'b1;
                cell_wr.data = sw_rec;
                cell_waddr   = r_sw_i;
                n_sw_i       = r_sw_i + AW'(1);
                if ((r_cx + DW'(1)) >= r_act_w) begin
                    n_cx = '0;
                    if (r_cy < r_act_h) begin
                        n_cy = r_cy + DW'(1);
                    end
                end else begin
                    n_cx = r_cx + DW'(1);
                end
                if (r_sw_i == AW'(CELLS - 1)) begin
                    n_size  = '0;
                    n_exp   = '0;
                    n_state = S_IDLE;
                    if (r_clr_reply) begin
                        done = 1'b1;
                    end
                end
            end
            // Take a request and issue its first reads.
            S_IDLE: begin
                if (i_start) begin
                    n_kind      = i_kind;
                    n_idx       = in_idx;
                    n_px        = i_pos_x;
                    n_py        = i_pos_y;
                    n_prx       = i_pred_in_x;
                    n_pry       = i_pred_in_y;
                    n_come      = i_in_cost_to_come;
                    n_go        = i_in_cost_to_go;
                    cell_raddr  = in_idx;
                    place_raddr = in_idx;
                    case (i_kind)
                        KIND_ENQ: begin
                            if (in_ok) begin
                                n_state = S_ENQ_WR;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        KIND_DEQ: begin
                            if (r_size == '0) begin
                                done = 1'b1;
                            end else begin
                                slot_ra_addr = '0;
                                slot_rb_addr = AW'(r_size - (AW+1)'(1));
                                n_size       = r_size - (AW+1)'(1);
                                n_state      = S_DEQ_TOP;
                            end
                        end
                        KIND_LKP: begin
                            if (in_ok) begin
                                n_state = S_LKP;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        default: begin
                            n_act_w     = sat_dim(r_grid_w, MAX_COLS);
                            n_act_h     = sat_dim(r_grid_h, MAX_ROWS);
                            n_sw_i      = '0;
                            n_cx        = '0;
                            n_cy        = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLR;
                        end
                    endcase
                end
            end
            // Lookup returns the stored record.
            S_LKP: begin
                done    = 1'b1;
                res_rec = cell_rd;
            end
            // Enqueue writes the record and places the cell in the heap.
            S_ENQ_WR: begin
                n_rec.status = ST_QUEUED;
                n_rec.self_x = r_px;
                n_rec.self_y = r_py;
                n_rec.pred_x = r_prx;
                n_rec.pred_y = r_pry;
                n_rec.come   = r_come;
                n_rec.go     = r_go;
                cell_wr.en   = 1'b1;
                cell_wr.data = n_rec;
                n_item       = {KEYW'(r_come) + KEYW'(r_go), r_idx};
                if (cell_rd.status == ST_QUEUED) begin
                    n_pos   = place_rd;
                    n_state = S_SU_RD;
                end else if (r_size < (AW+1)'(CELLS)) begin
                    n_pos   = AW'(r_size);
                    n_size  = r_size + (AW+1)'(1);
                    n_exp   = r_exp + EXPW'(1);
                    n_state = S_SU_RD;
                end else begin
                    done    = 1'b1;
                    res_rec = n_rec;
                end
            end
            // Dequeue: take the top and move the last entry to the root.
            S_DEQ_TOP: begin
                n_top = slot_ra[AW-1:0];
                if (r_size != '0) begin
                    n_item  = slot_rb;
                    n_pos   = '0;
                    n_state = S_SD_RD;
                end else begin
                    n_state = S_FIN_RD;
                end
            end
            // Sift up: read the parent.
            S_SU_RD: begin
                if (r_pos == '0) begin
                    slot_we  = 1'b1;
                    place_we = 1'b1;
                    n_state  = S_SD_RD;
                end else begin
                    slot_ra_addr = par;
                    n_state      = S_SU_CMP;
                end
            end
            // Sift up: move the parent down or settle the entry.
            S_SU_CMP: begin
                slot_we  = 1'b1;
                place_we = 1'b1;
                if (r_item < slot_ra) begin
                    slot_wdata  = slot_ra;
                    place_waddr = slot_ra[AW-1:0];
                    n_pos       = par;
                    n_state     = S_SU_RD;
                end else begin
                    n_state = S_SD_RD;
                end
            end
            // Sift down: read both children.
            S_SD_RD: begin
                if (lft >= r_size) begin
                    slot_we   = 1'b1;
                    place_we  = 1'b1;
                    heap_done = 1'b1;
                end else begin
                    slot_ra_addr = AW'(lft);
                    slot_rb_addr = AW'(rgt);
                    n_state      = S_SD_CMP;
                end
            end
            // Sift down: move the lesser child up or settle the entry.
            S_SD_CMP: begin
                slot_we  = 1'b1;
                place_we = 1'b1;
                if (best < r_item) begin
                    slot_wdata  = best;
                    place_waddr = best[AW-1:0];
                    n_pos       = best_pos;
                    n_state     = S_SD_RD;
                end else begin
                    heap_done = 1'b1;
                end
            end
            // Dequeue: read the removed cell's record.
            S_FIN_RD: begin
                cell_raddr = r_top;
                n_state    = S_FIN;
            end
            // Dequeue: mark the cell closed and return it.
            S_FIN: begin
                res_rec        = cell_rd;
                res_rec.status = ST_CLOSED;
                cell_wr.en     = 1'b1;
                cell_wr.data   = res_rec;
                cell_waddr     = r_top;
                done           = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // End of a heap walk.
        if (heap_done) begin
            if (r_kind == KIND_DEQ) begin
                n_state = S_FIN_RD;
            end else begin
                done    = 1'b1;
                res_rec = r_rec;
            end
        end

        // Result register.
        if (done) begin
            n_valid     = 1'b1;
            n_out       = res_rec;
            n_out_empty = (n_size == '0);
            n_out_exp   = n_exp;
            n_state     = S_IDLE;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_grid_w    <= DIM_RESET;
            r_grid_h    <= DIM_RESET;
            r_act_w     <= sat_dim(DIM_RESET, MAX_COLS);
            r_act_h     <= sat_dim(DIM_RESET, MAX_ROWS);
            r_size      <= '0;
            r_exp       <= '0;
            r_sw_i      <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_clr_reply <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_act_w     <= n_act_w;
            r_act_h     <= n_act_h;
            r_size      <= n_size;
            r_exp       <= n_exp;
            r_sw_i      <= n_sw_i;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_clr_reply <= n_clr_reply;
            r_valid     <= n_valid;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_WIDTH) begin
                    r_grid_w <= i_cfg_data;
                end else if (i_cfg_index == CFG_HEIGHT) begin
                    r_grid_h <= i_cfg_data;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_idx       <= n_idx;
        r_px        <= n_px;
        r_py        <= n_py;
        r_prx       <= n_prx;
        r_pry       <= n_pry;
        r_come      <= n_come;
        r_go        <= n_go;
        r_rec       <= n_rec;
        r_top       <= n_top;
        r_item      <= n_item;
        r_pos       <= n_pos;
        r_out       <= n_out;
        r_out_empty <= n_out_empty;
        r_out_exp   <= n_out_exp;
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_cfg_ready         = 1'b1;
    assign o_valid             = r_valid;
    assign o_node_status       = r_out.status;
    assign o_node_x            = r_out.self_x;
    assign o_node_y            = r_out.self_y;
    assign o_node_pred_x       = r_out.pred_x;
    assign o_node_pred_y       = r_out.pred_y;
    assign o_node_cost_to_come = r_out.come;
    assign o_node_cost_to_go   = r_out.go;
    assign o_queue_empty       = r_out_empty;
    assign o_expansions        = r_out_exp;

    // A result is only shown once the sequencer is back at rest.
    `GOLHC_ASSERT_IMPL(a_res_idle, r_valid, r_state == S_IDLE)
    // An accepted request either keeps the block busy or answers at once.
    `GOLHC_ASSERT_NEXT(a_req_busy, i_start && !o_busy, o_busy || r_valid)
    // The heap never holds more entries than there are cells.
    `GOLHC_ASSERT_NEVER(a_size_max, r_size > (AW+1)'(CELLS))

endmodule

// ===== tb/tb_grid_open_list_heap_core.sv =====
// ----------------------------------------------------------------------------
// tb_grid_open_list_heap_core
// Self-checking bench for the grid open list heap core. A queue of requests
// built up front feeds a clocked driver. A predictor computes the expected
// cell record for every accepted request. A monitor compares each result
// strobe with the oldest expected record, field by field.
// ----------------------------------------------------------------------------
module tb_grid_open_list_heap_core;
    import golh_pkg::*;

    localparam int NCELLS = MAX_COLS_DEF * MAX_ROWS_DEF;

    // One entry of the request list: an operation, a register write or a
    // pause until every outstanding result has come back.
    typedef struct {
        bit               is_cfg;
        bit               is_pause;
        bit               quiet;
        logic             cfg_idx;
        logic [DW-1:0]    cfg_val;
        logic [1:0]       kind;
        logic [CW-1:0]    x, y, px, py;
        logic [COSTW-1:0] come, go;
    } t_req;

    typedef struct {
        logic [1:0]       status;
        logic [CW-1:0]    x, y, px, py;
        logic [COSTW-1:0] come, go;
        logic             empty;
        logic [EXPW-1:0]  expn;
    } t_node;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    logic [1:0]          i_kind = KIND_LKP;
    logic [CW-1:0]       i_pos_x = '0, i_pos_y = '0, i_pred_in_x = '0, i_pred_in_y = '0;
    logic [COSTW-1:0]    i_in_cost_to_come = '0, i_in_cost_to_go = '0;
    logic                i_cfg_valid = 1'b0;
    logic                i_cfg_index = CFG_WIDTH;
    logic [DW-1:0]       i_cfg_data = '0;
    logic                o_busy, o_cfg_ready, o_valid, o_queue_empty;
    logic [1:0]          o_node_status;
    logic [CW-1:0]       o_node_x, o_node_y, o_node_pred_x, o_node_pred_y;
    logic [COSTW-1:0]    o_node_cost_to_come, o_node_cost_to_go;
    logic [EXPW-1:0]     o_expansions;

    grid_open_list_heap_core i_dut (.*);

    // Clock: period of 12 time units.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predicted state of the node table and open list.
    logic [1:0]       cell_st   [NCELLS];
    logic [11:0]      cell_from [NCELLS];
    logic [COSTW-1:0] cell_come [NCELLS];
    logic [COSTW-1:0] cell_go   [NCELLS];
    int               open_cells[$];
    logic [EXPW-1:0]  pushes;
    int               dim_w_reg, dim_h_reg, grid_w, grid_h;

    t_req   req_q[$];
    t_node  node_q[$];
    bit     quiet_mode;
    int     errors, gap, n_done, n_enq, n_deq, n_lkp, n_clr, n_cfg;
    bit     feed_done;

    // Sweep the node table with the latched grid size.
    function automatic void sweep_table();
        grid_w = (dim_w_reg > MAX_COLS_DEF) ? MAX_COLS_DEF : dim_w_reg;
        grid_h = (dim_h_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : dim_h_reg;
        for (int i = 0; i < NCELLS; i++) begin
            cell_st[i]   = ST_UNVISITED;
            cell_come[i] = INF_COST;
            cell_go[i]   = '0;
            if (i < grid_w * grid_h) begin
                cell_from[i] = {6'((i / grid_w) % 64), 6'((i % grid_w) % 64)};
            end else begin
                cell_from[i] = '0;
            end
        end
        open_cells.delete();
        pushes = '0;
    endfunction

    // Strict priority: lower total cost, then lower linear index.
    function automatic bit ranks_first(int a, int b);
        logic [KEYW-1:0] ta, tb;
        ta = {1'b0, cell_come[a]} + {1'b0, cell_go[a]};
        tb = {1'b0, cell_come[b]} + {1'b0, cell_go[b]};
        if (ta != tb) return ta < tb;
        return a < b;
    endfunction

    // Work out the record returned for one request and update the state.
    function automatic t_node predict_node(t_req r);
        t_node n;
        bit    in_grid;
        int    idx, best;
        n = '{status: ST_NONE, x: '0, y: '0, px: '0, py: '0, come: INF_COST,
              go: '0, empty: 1'b0, expn: '0};
        in_grid = (int'(r.x) < grid_w) && (int'(r.y) < grid_h);
        idx = in_grid ? int'(r.y) * grid_w + int'(r.x) : 0;
        best = -1;
        case (r.kind)
            KIND_ENQ: begin
                if (in_grid) begin
                    if (cell_st[idx] != ST_QUEUED) begin
                        open_cells.insert(open_cells.size(), idx);
                        pushes++;
                    end
                    cell_st[idx]   = ST_QUEUED;
                    cell_from[idx] = {r.py, r.px};
                    cell_come[idx] = r.come;
                    cell_go[idx]   = r.go;
                    best = idx;
                end
            end
            KIND_DEQ: begin
                if (open_cells.size() > 0) begin
                    int at;
                    at = 0;
                    for (int k = 1; k < open_cells.size(); k++) begin
                        if (ranks_first(open_cells[k], open_cells[at])) at = k;
                    end
                    best = open_cells[at];
                    open_cells.delete(at);
                    cell_st[best] = ST_CLOSED;
                end
            end
            KIND_LKP: begin
                if (in_grid) best = idx;
            end
            default: sweep_table();
        endcase
        if (best >= 0) begin
            n.status = cell_st[best];
            n.x      = 6'(best % grid_w);
            n.y      = 6'(best / grid_w);
            n.px     = cell_from[best][5:0];
            n.py     = cell_from[best][11:6];
            n.come   = cell_come[best];
            n.go     = cell_go[best];
        end
        n.empty = (open_cells.size() == 0);
        n.expn  = pushes;
        return n;
    endfunction

    // Driver: takes requests off the list, inserts random idle bursts.
    always @(posedge i_clk) begin
        logic nxt_start, nxt_cfg;
        t_req r;
        if (i_rst_n) begin
            nxt_start = i_start;
            nxt_cfg   = i_cfg_valid;
            if (i_start && !o_busy) begin
                r = '{is_cfg: 0, is_pause: 0, quiet: 0, cfg_idx: 0, cfg_val: 0,
                      kind: i_kind, x: i_pos_x, y: i_pos_y, px: i_pred_in_x,
                      py: i_pred_in_y, come: i_in_cost_to_come, go: i_in_cost_to_go};
                node_q.insert(node_q.size(), predict_node(r));
                case (i_kind)
                    KIND_ENQ: n_enq++;
                    KIND_DEQ: n_deq++;
                    KIND_LKP: n_lkp++;
                    default:  n_clr++;
                endcase
                nxt_start = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_WIDTH) dim_w_reg = int'(i_cfg_data);
                else dim_h_reg = int'(i_cfg_data);
                n_cfg++;
                nxt_cfg = 1'b0;
            end
            if (!nxt_start && !nxt_cfg) begin
                if (gap > 0) begin
                    gap--;
                end else if (req_q.size() > 0) begin
                    r = req_q[0];
                    if (r.is_pause || r.is_cfg) begin
                        // Only when nothing is in flight and the core is idle.
                        if (node_q.size() == 0 && !i_start && !o_busy) begin
                            void'(req_q.pop_front());
                            if (r.is_cfg) begin
                                nxt_cfg = 1'b1;
                                i_cfg_index <= r.cfg_idx;
                                i_cfg_data  <= r.cfg_val;
                            end
                        end
                    end else begin
                        void'(req_q.pop_front());
                        nxt_start = 1'b1;
                        i_kind            <= r.kind;
                        i_pos_x           <= r.x;
                        i_pos_y           <= r.y;
                        i_pred_in_x       <= r.px;
                        i_pred_in_y       <= r.py;
                        i_in_cost_to_come <= r.come;
                        i_in_cost_to_go   <= r.go;
                    end
                    if (!r.quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 7);
                end else begin
                    feed_done = 1'b1;
                end
            end
            i_start     <= nxt_start;
            i_cfg_valid <= nxt_cfg;
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
            errors++;
        end
    endfunction

    // Monitor: every result strobe is matched to the oldest expected record.
    always @(posedge i_clk) begin
        t_node n;
        if (i_rst_n && o_valid) begin
            if (node_q.size() == 0) begin
                $display("%0t: result with nothing expected, status %0d", $realtime,
                         o_node_status);
                errors++;
            end else begin
                n = node_q.pop_front();
                check_field("status", 32'(n.status), 32'(o_node_status));
                check_field("x", 32'(n.x), 32'(o_node_x));
                check_field("y", 32'(n.y), 32'(o_node_y));
                check_field("pred_x", 32'(n.px), 32'(o_node_pred_x));
                check_field("pred_y", 32'(n.py), 32'(o_node_pred_y));
                check_field("cost_to_come", 32'(n.come), 32'(o_node_cost_to_come));
                check_field("cost_to_go", 32'(n.go), 32'(o_node_cost_to_go));
                check_field("queue_empty", 32'(n.empty), 32'(o_queue_empty));
                check_field("expansions", n.expn, o_expansions);
                n_done++;
            end
        end
    end

    task automatic add_op(logic [1:0] k, int x, int y, int px, int py,
                          logic [COSTW-1:0] c, logic [COSTW-1:0] g);
        t_req r;
        r = '{is_cfg: 0, is_pause: 0, quiet: quiet_mode, cfg_idx: 0, cfg_val: 0,
              kind: k, x: 6'(x), y: 6'(y), px: 6'(px), py: 6'(py), come: c, go: g};
        req_q.insert(req_q.size(), r);
    endtask

    task automatic add_cfg(logic idx, int v);
        t_req r;
        r = '{is_cfg: 1, is_pause: 0, quiet: quiet_mode, cfg_idx: idx, cfg_val: 7'(v),
              kind: KIND_LKP, x: 0, y: 0, px: 0, py: 0, come: 0, go: 0};
        req_q.insert(req_q.size(), r);
    endtask

    task automatic add_pause();
        t_req r;
        r = '{is_cfg: 0, is_pause: 1, quiet: quiet_mode, cfg_idx: 0, cfg_val: 0,
              kind: KIND_LKP, x: 0, y: 0, px: 0, py: 0, come: 0, go: 0};
        req_q.insert(req_q.size(), r);
    endtask

    // Random phase on one grid size; mostly in-grid enqueues and dequeues.
    task automatic add_phase(int w, int h, int count);
        int ew, eh, sel, x, y;
        logic [COSTW-1:0] c, g;
        add_cfg(CFG_WIDTH, w);
        add_cfg(CFG_HEIGHT, h);
        add_op(KIND_CLR, 0, 0, 0, 0, 0, 0);
        ew = (w > 64) ? 64 : w;
        eh = (h > 64) ? 64 : h;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 199);
            if (ew > 0 && eh > 0 && $urandom_range(0, 9) != 0) begin
                x = $urandom_range(0, ew - 1);
                y = $urandom_range(0, eh - 1);
            end else begin
                x = $urandom_range(0, 63);
                y = $urandom_range(0, 63);
            end
            case ($urandom_range(0, 5))
                0: begin
                    c = COSTW'($urandom_range(0, 7));
                    g = COSTW'($urandom_range(0, 7));
                end
                1: begin c = INF_COST; g = COSTW'($urandom()); end
                default: begin c = COSTW'($urandom()); g = COSTW'($urandom()); end
            endcase
            if (sel < 100) add_op(KIND_ENQ, x, y, $urandom_range(0, 63),
                                  $urandom_range(0, 63), c, g);
            else if (sel < 155) add_op(KIND_DEQ, x, y, 0, 0, 0, 0);
            else if (sel < 198) add_op(KIND_LKP, x, y, 0, 0, 0, 0);
            else add_op(KIND_CLR, x, y, 0, 0, 0, 0);
        end
    endtask

    // Reset, request list and end of run.
    initial begin
        errors = 0; gap = 0; n_done = 0; feed_done = 0; quiet_mode = 0;
        n_enq = 0; n_deq = 0; n_lkp = 0; n_clr = 0; n_cfg = 0;
        dim_w_reg = 64; dim_h_reg = 64;
        sweep_table();

        // Directed: corners, cost extremes, ties, re-enqueue, empty list.
        add_op(KIND_LKP, 0, 0, 0, 0, 0, 0);
        add_op(KIND_LKP, 63, 63, 0, 0, 0, 0);
        add_op(KIND_ENQ, 5, 5, 0, 0, 0, 0);
        add_op(KIND_ENQ, 63, 63, 63, 63, INF_COST, INF_COST);
        add_op(KIND_ENQ, 1, 0, 2, 3, 3, 2);
        add_op(KIND_ENQ, 0, 1, 4, 5, 4, 1);
        add_op(KIND_ENQ, 5, 5, 9, 9, 100, 100);
        repeat (4) add_op(KIND_DEQ, 0, 0, 0, 0, 0, 0);
        add_op(KIND_DEQ, 0, 0, 0, 0, 0, 0);
        add_op(KIND_ENQ, 1, 0, 7, 7, 24'h800000, 24'h7FFFFF);
        add_op(KIND_LKP, 1, 0, 0, 0, 0, 0);
        add_pause();
        add_cfg(CFG_WIDTH, 0);
        add_cfg(CFG_HEIGHT, 127);
        add_op(KIND_CLR, 0, 0, 0, 0, 0, 0);
        add_op(KIND_ENQ, 0, 0, 1, 1, 1, 1);
        add_op(KIND_LKP, 0, 0, 0, 0, 0, 0);
        add_op(KIND_DEQ, 0, 0, 0, 0, 0, 0);
        add_cfg(CFG_WIDTH, 127);
        add_cfg(CFG_HEIGHT, 1);
        add_op(KIND_CLR, 0, 0, 0, 0, 0, 0);
        add_op(KIND_LKP, 63, 0, 0, 0, 0, 0);
        add_op(KIND_LKP, 0, 1, 0, 0, 0, 0);
        // A width write between clears must not take effect yet.
        add_cfg(CFG_WIDTH, 3);
        add_op(KIND_LKP, 40, 0, 0, 0, 0, 0);

        add_phase(64, 64, 260);
        add_phase(5, 4, 260);
        add_phase(1, 1, 100);
        add_phase(0, 3, 40);
        add_phase(127, 100, 240);
        add_pause();
        add_phase(2, 64, 200);
        quiet_mode = 1;
        add_phase(64, 3, 220);
        add_phase(64, 64, 350);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(feed_done && node_q.size() == 0 && !i_start)) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Covered %0d enqueues, %0d dequeues, %0d lookups, %0d clears", n_enq,
                 n_deq, n_lkp, n_clr);
        $display("over %0d register writes; %0d results checked.", n_cfg, n_done);
        if (errors == 0 && node_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #30000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
